>>> rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    // Depth of the byte buffer shared by write and read transfers.
    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_EVENT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAILED  = 2'd1,
        ST_PENDING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_TX    = 3'd3,
        ACT_RCEN  = 3'd4,
        ACT_ACK   = 3'd5
    } act_t;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_SEND_SLV  = 12'b0000_0000_0010,
        PH_AFTER_SLV = 12'b0000_0000_0100,
        PH_SEND_DATA = 12'b0000_0000_1000,
        PH_RESTART   = 12'b0000_0001_0000,
        PH_START2    = 12'b0000_0010_0000,
        PH_READ_REQ  = 12'b0000_0100_0000,
        PH_FIRST_RX  = 12'b0000_1000_0000,
        PH_RX_BYTE   = 12'b0001_0000_0000,
        PH_EN_RX     = 12'b0010_0000_0000,
        PH_SUCCESS   = 12'b0100_0000_0000,
        PH_FAIL      = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [5:0] byte_count;
        logic [4:0] buffer_index;
        logic [7:0] buffer_value;
        logic       ack_received;
        logic       bus_collision;
        logic [7:0] received_byte;
    } item_t;

    typedef struct packed {
        logic       accepted;
        status_t    status;
        act_t       bus_action;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [4:0] rx_index;
        logic [7:0] rx_byte;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

endpackage

>>> rtl/core/i2cms_in_reg.sv
module i2cms_in_reg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [i2cms_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [i2cms_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                             advance,
    output logic                             item_valid,
    output i2cms_pkg::item_t                 item
);

    logic             valid_reg, valid_next;
    i2cms_pkg::item_t item_reg, item_next;
    logic             take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next               = item_reg;
        valid_next              = valid_reg;
        if (advance) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next                 = 1'b1;
            item_next.command          = i2cms_pkg::cmd_t'(s_tuser[1:0]);
            item_next.dev_addr         = s_tdata[7:0];
            item_next.reg_addr         = s_tdata[15:8];
            item_next.byte_count       = s_tdata[21:16];
            item_next.buffer_index     = s_tdata[26:22];
            item_next.buffer_value     = s_tdata[34:27];
            item_next.ack_received     = s_tdata[35];
            item_next.bus_collision    = s_tdata[36];
            item_next.received_byte    = s_tdata[44:37];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/i2cms_buf.sv
module i2cms_buf (
    input  logic                              aclk,
    input  i2cms_pkg::buf_wr_t                wr,
    input  logic [i2cms_pkg::BUF_AW-1:0]      rd_addr,
    output logic [7:0]                        rd_data
);

    logic [7:0] mem_reg [i2cms_pkg::BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // The read port returns the entry as it stands after this edge, so a write
    // to the address being read is passed straight through.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (wr.en && wr.addr == rd_addr) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/i2cms_seq.sv
module i2cms_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  i2cms_pkg::item_t              item,
    input  logic [7:0]                    rd_data,
    output logic [i2cms_pkg::BUF_AW-1:0]  rd_addr,
    output i2cms_pkg::buf_wr_t            wr,
    output i2cms_pkg::result_t            res
);

    i2cms_pkg::phase_t  phase_reg, phase_next;
    i2cms_pkg::status_t status_reg, status_next;
    logic               is_read_reg, is_read_next;
    logic [7:0]         target_reg, target_next;
    logic [7:0]         regaddr_reg, regaddr_next;
    logic [5:0]         count_reg, count_next;
    logic [5:0]         position_reg, position_next;

    logic [7:0] pos_ext;
    logic [7:0] nxt_ext;
    logic [7:0] idx_ext;
    logic [5:0] pos_inc;
    logic       more_tx;
    logic       pos_in_buf;
    logic       idx_in_buf;
    logic       count_ok;

    // The buffer is read ahead, at the position the next word uses, so its registered data is ready for that word.
    assign pos_ext    = 8'(position_reg);
    assign nxt_ext    = 8'(position_next);
    assign idx_ext    = 8'(item.buffer_index);
    assign rd_addr    = nxt_ext[i2cms_pkg::BUF_AW-1:0];
    assign pos_inc    = position_reg + 6'd1;
    assign more_tx    = position_reg < count_reg;
    assign pos_in_buf = 9'(position_reg) < 9'(i2cms_pkg::BUF_DEPTH);
    assign idx_in_buf = 9'(item.buffer_index) < 9'(i2cms_pkg::BUF_DEPTH);
    assign count_ok   = 9'(item.byte_count) <= 9'(i2cms_pkg::BUF_DEPTH);

    always_comb begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        is_read_next  = is_read_reg;
        target_next   = target_reg;
        regaddr_next  = regaddr_reg;
        count_next    = count_reg;
        position_next = position_reg;
        wr            = '0;
        res           = '0;
        res.bus_action = i2cms_pkg::ACT_NONE;

        if (advance) begin
            unique case (item.command)
                i2cms_pkg::CMD_LOAD: begin
                    if (idx_in_buf) begin
                        wr.en   = 1'b1;
                        wr.addr = idx_ext[i2cms_pkg::BUF_AW-1:0];
                        wr.data = item.buffer_value;
                    end
                end
                i2cms_pkg::CMD_WRITE, i2cms_pkg::CMD_READ: begin
                    if (status_reg != i2cms_pkg::ST_PENDING && count_ok) begin
                        res.accepted   = 1'b1;
                        res.bus_action = i2cms_pkg::ACT_START;
                        target_next    = item.dev_addr;
                        if (item.command == i2cms_pkg::CMD_READ) begin
                            regaddr_next = item.reg_addr;
                        end
                        count_next    = item.byte_count;
                        position_next = '0;
                        is_read_next  = (item.command == i2cms_pkg::CMD_READ);
                        status_next   = i2cms_pkg::ST_PENDING;
                        phase_next    = i2cms_pkg::PH_SEND_SLV;
                    end
                end
                i2cms_pkg::CMD_EVENT: begin
                    if (phase_reg != i2cms_pkg::PH_IDLE) begin
                        if (item.bus_collision) begin
                            res.bus_action = i2cms_pkg::ACT_STOP;
                            phase_next     = i2cms_pkg::PH_FAIL;
                        end else begin
                            unique case (phase_reg)
                                i2cms_pkg::PH_SEND_SLV: begin
                                    res.bus_action = i2cms_pkg::ACT_TX;
                                    res.tx_byte    = target_reg;
                                    phase_next     = i2cms_pkg::PH_AFTER_SLV;
                                end
                                i2cms_pkg::PH_AFTER_SLV, i2cms_pkg::PH_SEND_DATA: begin
                                    if (!item.ack_received) begin
                                        res.bus_action = i2cms_pkg::ACT_STOP;
                                        phase_next     = i2cms_pkg::PH_FAIL;
                                    end else if (phase_reg == i2cms_pkg::PH_AFTER_SLV
                                                 && is_read_reg) begin
                                        res.bus_action = i2cms_pkg::ACT_TX;
                                        res.tx_byte    = regaddr_reg;
                                        phase_next     = i2cms_pkg::PH_RESTART;
                                    end else if (more_tx) begin
                                        res.bus_action = i2cms_pkg::ACT_TX;
                                        res.tx_byte    = rd_data;
                                        position_next  = pos_inc;
                                        phase_next     = i2cms_pkg::PH_SEND_DATA;
                                    end else begin
                                        res.bus_action = i2cms_pkg::ACT_STOP;
                                        phase_next     = i2cms_pkg::PH_SUCCESS;
                                    end
                                end
                                i2cms_pkg::PH_RESTART: begin
                                    res.bus_action = i2cms_pkg::ACT_STOP;
                                    phase_next     = i2cms_pkg::PH_START2;
                                end
                                i2cms_pkg::PH_START2: begin
                                    res.bus_action = i2cms_pkg::ACT_START;
                                    phase_next     = i2cms_pkg::PH_READ_REQ;
                                end
                                i2cms_pkg::PH_READ_REQ: begin
                                    res.bus_action = i2cms_pkg::ACT_TX;
                                    res.tx_byte    = target_reg + 8'd1;
                                    phase_next     = i2cms_pkg::PH_FIRST_RX;
                                end
                                i2cms_pkg::PH_FIRST_RX: begin
                                    if (item.ack_received) begin
                                        res.bus_action = i2cms_pkg::ACT_RCEN;
                                        phase_next     = i2cms_pkg::PH_RX_BYTE;
                                    end else begin
                                        res.bus_action = i2cms_pkg::ACT_STOP;
                                        phase_next     = i2cms_pkg::PH_FAIL;
                                    end
                                end
                                i2cms_pkg::PH_RX_BYTE: begin
                                    if (pos_in_buf) begin
                                        wr.en        = 1'b1;
                                        wr.addr      = pos_ext[i2cms_pkg::BUF_AW-1:0];
                                        wr.data      = item.received_byte;
                                        res.rx_valid = 1'b1;
                                        res.rx_index = position_reg[4:0];
                                        res.rx_byte  = item.received_byte;
                                    end
                                    position_next = pos_inc;
                                    if (pos_inc < count_reg) begin
                                        res.bus_action = i2cms_pkg::ACT_ACK;
                                        phase_next     = i2cms_pkg::PH_EN_RX;
                                    end else begin
                                        res.bus_action = i2cms_pkg::ACT_STOP;
                                        phase_next     = i2cms_pkg::PH_SUCCESS;
                                    end
                                end
                                i2cms_pkg::PH_EN_RX: begin
                                    res.bus_action = i2cms_pkg::ACT_RCEN;
                                    phase_next     = i2cms_pkg::PH_RX_BYTE;
                                end
                                i2cms_pkg::PH_SUCCESS: begin
                                    status_next = i2cms_pkg::ST_OK;
                                    phase_next  = i2cms_pkg::PH_IDLE;
                                end
                                i2cms_pkg::PH_FAIL: begin
                                    status_next = i2cms_pkg::ST_FAILED;
                                    phase_next  = i2cms_pkg::PH_IDLE;
                                end
                                default: begin
                                    phase_next = i2cms_pkg::PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res.status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= i2cms_pkg::PH_IDLE;
            status_reg   <= i2cms_pkg::ST_OK;
            is_read_reg  <= 1'b0;
            target_reg   <= '0;
            regaddr_reg  <= '0;
            count_reg    <= '0;
            position_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            status_reg   <= status_next;
            is_read_reg  <= is_read_next;
            target_reg   <= target_next;
            regaddr_reg  <= regaddr_next;
            count_reg    <= count_next;
            position_reg <= position_next;
        end
    end

endmodule

>>> rtl/core/i2c_master_transaction_sequencer.sv
// Flow: a word taken into the input register is processed when the result
// register is empty or being emptied, and its result is loaded there for m_tvalid.
// Throughput: one word per cycle while m_tready stays high; when a result waits
// for m_tready, the input register still takes one more word.
// Reset: aresetn is synchronous and active low; it returns the sequencer to idle
// with status success, while the byte buffer keeps its contents until written.
module i2c_master_transaction_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0: dev_addr[7:0], reg_addr[15:8], byte_count[21:16],
    // buffer_index[26:22], buffer_value[34:27], ack_received[35],
    // bus_collision[36], received_byte[44:37], zero padding[47:45].
    input  logic [i2cms_pkg::S_TDATA_W-1:0]  s_tdata,
    // From bit 0: command[1:0] (load, start write, start read, bus event).
    input  logic [i2cms_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: accepted[0], status[2:1], bus_action[5:3], tx_byte[13:6],
    // rx_valid[14], rx_index[19:15], rx_byte[27:20], zero padding[31:28].
    output logic [i2cms_pkg::M_TDATA_W-1:0]  m_tdata
);

    // The input register holds one word. It is processed in the cycle when the
    // result register is empty or is being emptied; the sequencer state and the
    // buffer update at that same edge, so the next word sees the new state.
    logic                               item_valid;
    i2cms_pkg::item_t                   item;
    logic                               advance;
    logic [i2cms_pkg::BUF_AW-1:0]       rd_addr;
    logic [7:0]                         rd_data;
    i2cms_pkg::buf_wr_t                 wr;
    i2cms_pkg::result_t                 res;

    logic                               out_valid_reg, out_valid_next;
    i2cms_pkg::result_t                 out_data_reg, out_data_next;

    assign advance = item_valid && (!out_valid_reg || m_tready);

    i2cms_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // The buffer is read ahead at the transmit position the next word
    // will use, and written either by a load word or by a received byte.
    i2cms_buf u_buf (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    i2cms_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr      (wr),
        .res     (res)
    );

    // Result register: loaded whenever a word is processed, otherwise it holds
    // until the downstream side takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_data_reg.rx_byte,
                       out_data_reg.rx_index,
                       out_data_reg.rx_valid,
                       out_data_reg.tx_byte,
                       out_data_reg.bus_action,
                       out_data_reg.status,
                       out_data_reg.accepted};

    // A taken start request always opens with a start condition and leaves the
    // transfer pending.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_data_reg.accepted) |->
            (out_data_reg.bus_action == i2cms_pkg::ACT_START
             && out_data_reg.status == i2cms_pkg::ST_PENDING))
        else $error("accepted request without start or pending status");

    // A stored byte is always followed by either an acknowledge or the final stop.
    a_rx_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_data_reg.rx_valid) |->
            (out_data_reg.bus_action == i2cms_pkg::ACT_ACK
             || out_data_reg.bus_action == i2cms_pkg::ACT_STOP))
        else $error("received byte without ack or stop");

    // The input side only stalls when a word waits and the result side is full.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (item_valid && out_valid_reg && !m_tready))
        else $error("input stalled without back-pressure");

    // Every processed word produces exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed word produced no result");

endmodule

>>> bench/i2c_sequencer_checker.sv
module i2c_sequencer_checker
    import i2cms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the sequencer state.
    phase_t     seq_phase;
    status_t    xfer_status;
    logic       reading;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [5:0] xfer_count;
    logic [5:0] xfer_pos;
    logic [7:0] byte_buf [BUF_DEPTH];

    result_t    expected_q [$];
    int         mismatches = 0;

    // Sends the next buffered byte of a write, or the stop once all are out.
    function automatic void send_next(output act_t act, output logic [7:0] txb);
        txb = '0;
        if (xfer_pos < xfer_count) begin
            act       = ACT_TX;
            txb       = byte_buf[xfer_pos[4:0]];
            xfer_pos  = xfer_pos + 6'd1;
            seq_phase = PH_SEND_DATA;
        end else begin
            act       = ACT_STOP;
            seq_phase = PH_SUCCESS;
        end
    endfunction

    function automatic result_t predict_word(cmd_t cmd, logic [S_TDATA_W-1:0] d);
        logic [7:0] saddr;
        logic [7:0] daddr;
        logic [5:0] bcount;
        logic [4:0] bidx;
        logic [7:0] bval;
        logic       ack;
        logic       coll;
        logic [7:0] rcv;
        act_t       act;
        logic [7:0] txb;
        result_t    r;
        saddr  = d[7:0];
        daddr  = d[15:8];
        bcount = d[21:16];
        bidx   = d[26:22];
        bval   = d[34:27];
        ack    = d[35];
        coll   = d[36];
        rcv    = d[44:37];
        r      = '0;
        act    = ACT_NONE;
        txb    = '0;
        case (cmd)
            CMD_LOAD: begin
                byte_buf[bidx] = bval;
            end
            CMD_WRITE, CMD_READ: begin
                if (xfer_status != ST_PENDING && bcount <= BUF_DEPTH) begin
                    r.accepted = 1'b1;
                    slave_addr = saddr;
                    if (cmd == CMD_READ) reg_addr = daddr;
                    xfer_count  = bcount;
                    xfer_pos    = '0;
                    reading     = (cmd == CMD_READ);
                    xfer_status = ST_PENDING;
                    seq_phase   = PH_SEND_SLV;
                    act         = ACT_START;
                end
            end
            default: begin
                if (seq_phase != PH_IDLE) begin
                    if (coll) begin
                        act       = ACT_STOP;
                        seq_phase = PH_FAIL;
                    end else begin
                        case (seq_phase)
                            PH_SEND_SLV: begin
                                act       = ACT_TX;
                                txb       = slave_addr;
                                seq_phase = PH_AFTER_SLV;
                            end
                            PH_AFTER_SLV: begin
                                if (!ack) begin
                                    act       = ACT_STOP;
                                    seq_phase = PH_FAIL;
                                end else if (reading) begin
                                    act       = ACT_TX;
                                    txb       = reg_addr;
                                    seq_phase = PH_RESTART;
                                end else begin
                                    send_next(act, txb);
                                end
                            end
                            PH_SEND_DATA: begin
                                if (!ack) begin
                                    act       = ACT_STOP;
                                    seq_phase = PH_FAIL;
                                end else begin
                                    send_next(act, txb);
                                end
                            end
                            PH_RESTART: begin
                                act       = ACT_STOP;
                                seq_phase = PH_START2;
                            end
                            PH_START2: begin
                                act       = ACT_START;
                                seq_phase = PH_READ_REQ;
                            end
                            PH_READ_REQ: begin
                                act       = ACT_TX;
                                txb       = slave_addr + 8'd1;
                                seq_phase = PH_FIRST_RX;
                            end
                            PH_FIRST_RX: begin
                                if (ack) begin
                                    act       = ACT_RCEN;
                                    seq_phase = PH_RX_BYTE;
                                end else begin
                                    act       = ACT_STOP;
                                    seq_phase = PH_FAIL;
                                end
                            end
                            PH_RX_BYTE: begin
                                if (xfer_pos < BUF_DEPTH) begin
                                    byte_buf[xfer_pos[4:0]] = rcv;
                                    r.rx_valid = 1'b1;
                                    r.rx_index = xfer_pos[4:0];
                                    r.rx_byte  = rcv;
                                end
                                xfer_pos = xfer_pos + 6'd1;
                                // Every byte but the last is acknowledged.
                                if (xfer_pos < xfer_count) begin
                                    act       = ACT_ACK;
                                    seq_phase = PH_EN_RX;
                                end else begin
                                    act       = ACT_STOP;
                                    seq_phase = PH_SUCCESS;
                                end
                            end
                            PH_EN_RX: begin
                                act       = ACT_RCEN;
                                seq_phase = PH_RX_BYTE;
                            end
                            PH_SUCCESS: begin
                                xfer_status = ST_OK;
                                seq_phase   = PH_IDLE;
                            end
                            PH_FAIL: begin
                                xfer_status = ST_FAILED;
                                seq_phase   = PH_IDLE;
                            end
                            default: begin
                                seq_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
        endcase
        r.bus_action = act;
        r.tx_byte    = txb;
        r.status     = xfer_status;
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            seq_phase   = PH_IDLE;
            xfer_status = ST_OK;
            reading     = 1'b0;
            slave_addr  = '0;
            reg_addr    = '0;
            xfer_count  = '0;
            xfer_pos    = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result word %h arrived with nothing expected", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("accepted",   8'(want.accepted),   8'(m_tdata[0]));
                    compare_field("status",     8'(want.status),     8'(m_tdata[2:1]));
                    compare_field("bus_action", 8'(want.bus_action), 8'(m_tdata[5:3]));
                    compare_field("tx_byte",    want.tx_byte,        m_tdata[13:6]);
                    compare_field("rx_valid",   8'(want.rx_valid),   8'(m_tdata[14]));
                    compare_field("rx_index",   8'(want.rx_index),   8'(m_tdata[19:15]));
                    compare_field("rx_byte",    want.rx_byte,        m_tdata[27:20]);
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_word(cmd_t'(s_tuser), s_tdata));
        end
        fail_count    <= mismatches;
        pending_count <= expected_q.size();
    end

endmodule

>>> bench/i2c_master_transaction_sequencer_tb.sv
module i2c_master_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // From bit 0: dev_addr, reg_addr, byte_count, buffer_index,
    // buffer_value, ack_received, bus_collision, received_byte, zero padding.
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // From bit 0: command.
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // From bit 0: accepted, status, bus_action, tx_byte, rx_valid, rx_index,
    // rx_byte, zero padding.
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;

    // Words left in the current sender burst, and the count of words that
    // belong to well-formed transfers (loads, start requests and bus events).
    int burst_left = 0;
    int seq_words  = 0;

    // Buffer entries that have been loaded at least once. A write must never
    // transmit an entry that was never written, so write counts are held to
    // the loaded prefix of the buffer.
    bit [BUF_DEPTH-1:0] loaded = '0;

    logic [15:0] ready_pattern = '1;
    int          pattern_left  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    i2c_master_transaction_sequencer u_dut (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata
    );

    i2c_sequencer_checker u_checker (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .fail_count,
        .pending_count
    );

    // The result side follows a 16-bit ready pattern that is picked anew
    // whenever its random run length is used up: always ready, a random pattern with at least one
    // ready slot, a long stall, or a fixed uneven pattern.
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;
                1:       ready_pattern = 16'($urandom) | 16'h0001;
                2:       ready_pattern = 16'h0FFF;
                default: ready_pattern = 16'hE6B5;
            endcase
            pattern_left = $urandom_range(16, 96);
        end
        m_tready <= ready_pattern[pattern_left % 16];
        pattern_left--;
    end

    // A word of the given command with every field random.
    function automatic item_t random_word(cmd_t c);
        item_t w;
        w.command       = c;
        w.dev_addr      = 8'($urandom);
        w.reg_addr      = 8'($urandom);
        w.byte_count    = 6'($urandom);
        w.buffer_index  = 5'($urandom);
        w.buffer_value  = 8'($urandom);
        w.ack_received  = 1'($urandom);
        w.bus_collision = 1'($urandom);
        w.received_byte = 8'($urandom);
        return w;
    endfunction

    // A bus event. A clean one always acknowledges and never collides; a
    // faulty one sometimes reports a NACK or a collision.
    function automatic item_t bus_event(bit faulty);
        item_t w;
        w = random_word(CMD_EVENT);
        w.ack_received  = faulty ? ($urandom_range(0, 14) != 0) : 1'b1;
        w.bus_collision = faulty && ($urandom_range(0, 19) == 0);
        return w;
    endfunction

    // Transfer sizes: mostly short, some medium, a few of the full buffer.
    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $urandom_range(0, 4);
        if (roll < 9) return $urandom_range(5, BUF_DEPTH - 1);
        return BUF_DEPTH;
    endfunction

    // Drives one word and returns at the edge where it is taken. At the start
    // of each burst a random gap (possibly none) holds tvalid low.
    task automatic send_word(input item_t w);
        int gap;
        int prefix;
        if (w.command == CMD_WRITE && w.byte_count <= BUF_DEPTH) begin
            prefix = 0;
            while (prefix < BUF_DEPTH && loaded[prefix]) prefix++;
            if (w.byte_count > prefix) w.byte_count = 6'(prefix);
        end
        if (w.command == CMD_LOAD) loaded[w.buffer_index] = 1'b1;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.command;
        s_tdata  <= {3'b000, w.received_byte, w.bus_collision, w.ack_received,
                     w.buffer_value, w.buffer_index, w.byte_count,
                     w.reg_addr, w.dev_addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Feeds a run of bus events. Now and then a stray load or start request
    // slips in between; a start while a transfer is pending gets refused.
    task automatic bus_events(int num, bit faulty);
        for (int i = 0; i < num; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_word(random_word(cmd_t'($urandom_range(0, 2))));
            send_word(bus_event(faulty));
            seq_words++;
        end
    endtask

    // Holds the input side idle until every expected result word is back.
    // The first edge lets the checker see the word accepted last.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        burst_left = $urandom_range(1, 24);
    endtask

    // A full write: fill the buffer entries it will send, request it, and give
    // it the events it needs to finish (address, one per byte, stop, status).
    task automatic write_transfer();
        int    n;
        bit    faulty;
        item_t w;
        n      = pick_size();
        faulty = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++) begin
            if (!loaded[i] || $urandom_range(0, 1)) begin
                w = random_word(CMD_LOAD);
                w.buffer_index = 5'(i);
                send_word(w);
                seq_words++;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            // Too many bytes for the buffer: refused.
            w = random_word(CMD_WRITE);
            w.byte_count = 6'($urandom_range(BUF_DEPTH + 1, 63));
            send_word(w);
        end
        w = random_word(CMD_WRITE);
        w.byte_count = 6'(n);
        send_word(w);
        seq_words++;
        bus_events(n + 3, faulty);
    endtask

    // A full read: six events up to the first receive enable, two per byte
    // but one less for the last, and one for the status. A zero count still
    // receives one byte.
    task automatic read_transfer();
        int    n;
        bit    faulty;
        item_t w;
        n      = pick_size();
        faulty = ($urandom_range(0, 2) == 0);
        w = random_word(CMD_READ);
        w.byte_count = 6'(n);
        send_word(w);
        seq_words++;
        bus_events(2 * ((n == 0) ? 1 : n) + 6, faulty);
    endtask

    initial begin
        item_t w;
        int    guard;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // A bus event with nothing in progress is ignored, even a collision.
        w = random_word(CMD_EVENT);
        w.bus_collision = 1'b1;
        w.ack_received  = 1'b1;
        w.received_byte = 8'hFF;
        send_word(w);

        w = random_word(CMD_LOAD);
        w.buffer_index = '0;
        w.buffer_value = 8'hFF;
        send_word(w);

        // One byte more than the buffer holds: refused.
        w = random_word(CMD_WRITE);
        w.byte_count = 6'(BUF_DEPTH + 1);
        send_word(w);

        // One-byte write to the top device address.
        w = random_word(CMD_WRITE);
        w.dev_addr   = 8'hFF;
        w.byte_count = 6'd1;
        send_word(w);
        bus_events(4, 1'b0);

        // Empty write: the stop follows the address. A read request while it
        // is pending gets refused.
        w = random_word(CMD_WRITE);
        w.dev_addr   = 8'h00;
        w.byte_count = '0;
        send_word(w);
        w = random_word(CMD_READ);
        w.byte_count = 6'd1;
        send_word(w);
        bus_events(3, 1'b0);

        // Empty read still takes in one byte; the read address wraps to zero.
        w = random_word(CMD_READ);
        w.dev_addr   = 8'hFF;
        w.reg_addr   = 8'hFF;
        w.byte_count = '0;
        send_word(w);
        bus_events(8, 1'b0);

        // NACK on the device address ends in a failed transfer.
        w = random_word(CMD_WRITE);
        w.byte_count = '0;
        send_word(w);
        send_word(bus_event(1'b0));
        w = bus_event(1'b0);
        w.ack_received = 1'b0;
        send_word(w);
        send_word(bus_event(1'b0));

        // Collision in the middle of a transfer.
        w = random_word(CMD_READ);
        w.byte_count = 6'd2;
        send_word(w);
        w = bus_event(1'b0);
        w.bus_collision = 1'b1;
        send_word(w);
        send_word(bus_event(1'b0));

        wait_all_results();

        // Random part: mostly well-formed transfers, the rest loose words.
        while (seq_words < 900) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: write_transfer();
                4, 5, 6, 7: read_transfer();
                default: begin
                    repeat ($urandom_range(1, 5))
                        send_word(random_word(cmd_t'($urandom_range(0, 3))));
                end
            endcase
            if ($urandom_range(0, 24) == 0) wait_all_results();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending_count != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        // Keep the clock running a little longer to catch any stray result word.
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: a correct run ends well before this.
    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_in_reg.sv
rtl/core/i2cms_buf.sv
rtl/core/i2cms_seq.sv
rtl/core/i2c_master_transaction_sequencer.sv
bench/i2c_sequencer_checker.sv
bench/i2c_master_transaction_sequencer_tb.sv
